// ----- rtl/core/krt_pkg.sv -----
// Shared types, codes and constants of the keyed record table.
package krt_pkg;

  localparam int          DefaultDepth = 64;
  localparam logic [11:0] TimeAtReset  = 12'd2016;
  localparam logic [15:0] HitsMax      = 16'hFFFF;

  localparam logic [1:0] FUNC_SEARCH = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  localparam logic [1:0] FUNC_SWEEP  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        vld;
    logic [15:0] key;
    logic [11:0] tm;
    logic [15:0] hits;
  } rec_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic stale;
  } eval_t;

endpackage

// ----- rtl/core/krt_mem.sv -----
// Record memory with one write port and one registered read port.
module krt_mem #(
  parameter int Depth = krt_pkg::DefaultDepth
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  krt_pkg::rec_t          wdata_i,
  input  logic                   re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output krt_pkg::rec_t          rdata_o
);
  import krt_pkg::*;

  rec_t mem_q [Depth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/krt_eval.sv -----
// Shared entry test: key compare, free check and age compare for one record.
module krt_eval (
  input  krt_pkg::rec_t  rec_i,
  input  logic [15:0]    key_i,
  input  logic [11:0]    cur_time_i,
  input  logic [11:0]    limit_i,
  output krt_pkg::eval_t res_o
);
  import krt_pkg::*;

  logic signed [12:0] age;

  // Age is a signed difference; an entry stamped in the future is never stale.
  assign age = $signed({1'b0, cur_time_i}) - $signed({1'b0, rec_i.tm});

  always_comb begin
    res_o.hit   = rec_i.vld && (rec_i.key == key_i);
    res_o.free  = !rec_i.vld;
    res_o.stale = rec_i.vld && (age > $signed({1'b0, limit_i}));
  end

endmodule

// ----- rtl/core/keyed_record_table_with_aging.sv -----
// Top level: keyed record table with age-based eviction and its sequencer.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------------------------
//  in      | in_valid_i / in_stall_o | func_i key_id_i visit_time_i age_limit_i
//  out     | out_valid_o/ out_stall_i| status_o hit_count_o seen_time_o removed_count_o
//  cfg     | cfg_we_i                | cfg_wdata_i (current time)
//
// Every operation walks all TABLE_DEPTH entries through the single memory read
// port, and no new item is taken until the previous one has finished.
// After reset a clearing pass over every entry runs before the first transfer.
// The result sits in an output register; a stalled result holds only the final
// step of the next item, which waits until the register frees up.
module keyed_record_table_with_aging #(
  parameter int TABLE_DEPTH = krt_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] key_id_i,
  input  logic [11:0] visit_time_i,
  input  logic [11:0] age_limit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] hit_count_o,
  output logic [11:0] seen_time_o,
  output logic [6:0]  removed_count_o
);
  import krt_pkg::*;

  localparam int         AW   = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [11:0]   cur_time_q, cur_time_d;
  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic [1:0]    op_q, op_d;
  logic [15:0]   key_q, key_d;
  logic [11:0]   vtime_q, vtime_d;
  logic [11:0]   limit_q, limit_d;

  logic          found_q, found_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic [15:0]   match_hits_q, match_hits_d;
  logic [11:0]   match_time_q, match_time_d;
  logic          free_found_q, free_found_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [6:0]    removed_q, removed_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   hits_q, hits_d;
  logic [11:0]   seen_q, seen_d;
  logic [6:0]    removed_out_q, removed_out_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata, mem_rdata;
  eval_t         ev;

  logic          in_xfer, out_xfer, fin_go;
  logic [15:0]   hits_inc;

  krt_mem #(
    .Depth (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  krt_eval u_eval (
    .rec_i      (mem_rdata),
    .key_i      (key_q),
    .cur_time_i (cur_time_q),
    .limit_i    (limit_q),
    .res_o      (ev)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign hits_inc   = (match_hits_q == HitsMax) ? HitsMax : match_hits_q + 16'd1;
  assign mem_re     = (state_q == S_SCAN);

  // Memory write port: clearing pass, sweep eviction, or the final insert/update.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (rd_pend_q && (op_q == FUNC_SWEEP) && ev.stale) begin
      mem_we        = 1'b1;
      mem_waddr     = rd_idx_q;
      mem_wdata     = mem_rdata;
      mem_wdata.vld = 1'b0;
    end else if (fin_go && (op_q == FUNC_INSERT) && !found_q && free_found_q) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx_q;
      mem_wdata = '{vld: 1'b1, key: key_q, tm: vtime_q, hits: 16'd1};
    end else if (fin_go && (op_q == FUNC_UPDATE) && found_q) begin
      mem_we    = 1'b1;
      mem_waddr = match_idx_q;
      mem_wdata = '{vld: 1'b1, key: key_q, tm: vtime_q, hits: hits_inc};
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cur_time_d    = cfg_we_i ? cfg_wdata_i : cur_time_q;
    rd_pend_d     = (state_q == S_SCAN);
    rd_idx_d      = cnt_q;
    op_d          = op_q;
    key_d         = key_q;
    vtime_d       = vtime_q;
    limit_d       = limit_q;
    found_d       = found_q;
    match_idx_d   = match_idx_q;
    match_hits_d  = match_hits_q;
    match_time_d  = match_time_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    removed_d     = removed_q;
    out_valid_d   = out_valid_q && !out_xfer;
    status_d      = status_q;
    hits_d        = hits_q;
    seen_d        = seen_q;
    removed_out_d = removed_out_q;

    // Record the first match and first free slot, and count stale entries in a sweep, as read data comes back.
    if (rd_pend_q) begin
      if (ev.hit && !found_q) begin
        found_d      = 1'b1;
        match_idx_d  = rd_idx_q;
        match_hits_d = mem_rdata.hits;
        match_time_d = mem_rdata.tm;
      end
      if (ev.free && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
      if ((op_q == FUNC_SWEEP) && ev.stale) begin
        removed_d = removed_q + 7'd1;
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_d         = func_i;
          key_d        = key_id_i;
          vtime_d      = visit_time_i;
          limit_d      = age_limit_i;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          removed_d    = '0;
          cnt_d        = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_d   = 1'b1;
          status_d      = ST_OK;
          hits_d        = '0;
          seen_d        = '0;
          removed_out_d = '0;
          unique case (op_q)
            FUNC_SEARCH: begin
              if (found_q) begin
                hits_d = match_hits_q;
                seen_d = match_time_q;
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            FUNC_INSERT: begin
              if (found_q) begin
                status_d = ST_DUPLICATE;
                hits_d   = match_hits_q;
                seen_d   = match_time_q;
              end else if (free_found_q) begin
                hits_d = 16'd1;
                seen_d = vtime_q;
              end else begin
                status_d = ST_FULL;
              end
            end
            FUNC_UPDATE: begin
              if (found_q) begin
                hits_d = hits_inc;
                seen_d = vtime_q;
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            FUNC_SWEEP: begin
              removed_out_d = removed_q;
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      cur_time_q   <= TimeAtReset;
      rd_pend_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      removed_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cur_time_q   <= cur_time_d;
      rd_pend_q    <= rd_pend_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      removed_q    <= removed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    op_q          <= op_d;
    key_q         <= key_d;
    vtime_q       <= vtime_d;
    limit_q       <= limit_d;
    match_idx_q   <= match_idx_d;
    match_hits_q  <= match_hits_d;
    match_time_q  <= match_time_d;
    free_idx_q    <= free_idx_d;
    status_q      <= status_d;
    hits_q        <= hits_d;
    seen_q        <= seen_d;
    removed_out_q <= removed_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign hit_count_o     = hits_q;
  assign seen_time_o     = seen_q;
  assign removed_count_o = removed_out_q;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != cnt_q))
    else $error("memory write and read hit the same entry");

  a_xfer_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");

  a_removed_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (removed_count_o == 7'd0))
    else $error("failed operation reports removed entries");

  a_full_no_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> ((hit_count_o == 16'd0) && (seen_time_o == 12'd0)))
    else $error("full-table result carries a record");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
    else $error("read data returned outside a table walk");
`endif

endmodule
